/* rtl/owrm_pkg.sv */
// Shared types, constants and slot timing helper for the one-wire register master.
// No dependencies; imported by every module of the block.
package owrm_pkg;

    // Read byte limit and field widths
    localparam int MAX_READ_BYTES = 64;
    localparam int TICK_W         = 10;
    localparam int LEFT_W         = 7;
    localparam int CFG_IDX_W      = 3;

    // Request codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_RECOV  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SLOT    = 3'd7;

    // Register reset values
    localparam logic [TICK_W-1:0] RST_RESET_LOW   = 10'd570;
    localparam logic [TICK_W-1:0] RST_PRES_WAIT   = 10'd80;
    localparam logic [TICK_W-1:0] RST_RESET_RECOV = 10'd300;
    localparam logic [TICK_W-1:0] RST_WRITE_LOW   = 10'd8;
    localparam logic [TICK_W-1:0] RST_WRITE_SLOT  = 10'd90;
    localparam logic [TICK_W-1:0] RST_WRITE_RECOV = 10'd10;
    localparam logic [TICK_W-1:0] RST_READ_LOW    = 10'd6;
    localparam logic [TICK_W-1:0] RST_READ_SLOT   = 10'd90;

    // Bus bytes
    localparam logic [7:0] SKIP_ROM_CMD = 8'hCC;
    localparam logic [7:0] READ_FLAG    = 8'h80;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_PRES_WAIT = 4'd2,
        PH_RECOVER   = 4'd3,
        PH_W_LOW     = 4'd4,
        PH_W_HOLD    = 4'd5,
        PH_W_REC     = 4'd6,
        PH_R_LOW     = 4'd7,
        PH_R_SAMPLE  = 4'd8,
        PH_R_WAIT    = 4'd9
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low_ticks;
        logic [TICK_W-1:0] presence_wait_ticks;
        logic [TICK_W-1:0] reset_recover_ticks;
        logic [TICK_W-1:0] write_low_ticks;
        logic [TICK_W-1:0] write_slot_ticks;
        logic [TICK_W-1:0] write_recover_ticks;
        logic [TICK_W-1:0] read_low_ticks;
        logic [TICK_W-1:0] read_slot_ticks;
    } t_owrm_cfg;

    typedef struct packed {
        t_phase            phase;
        logic [TICK_W-1:0] slot_timer;
        logic [2:0]        bit_counter;
        logic [7:0]        shift_byte;
        logic [1:0]        byte_stage;
        logic [LEFT_W-1:0] bytes_left;
        logic              is_read;
        logic              chosen_line;
        logic [7:0]        saved_addr;
        logic [7:0]        saved_data;
    } t_owrm_state;

    typedef struct packed {
        logic [1:0] func;
        logic       line_sel;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       line_sample;
    } t_owrm_item;

    typedef struct packed {
        logic       drive_enable;
        logic       drive_level;
        logic       active_line;
        logic       busy_res;
        logic       presence_valid;
        logic       present;
        logic       byte_valid;
        logic [7:0] read_data;
        logic       byte_last;
    } t_owrm_result;

    // A zero duration counts as one tick
    function automatic logic [TICK_W-1:0] f_nz(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    // Slot length loaded on entry to a phase
    function automatic logic [TICK_W-1:0] f_slot_ticks(input t_phase ph, input t_owrm_cfg c);
        logic [TICK_W-1:0] t;
        case (ph)
            PH_RST_LOW:   t = f_nz(c.reset_low_ticks);
            PH_PRES_WAIT: t = f_nz(c.presence_wait_ticks);
            PH_RECOVER:   t = f_nz(c.reset_recover_ticks);
            PH_W_LOW:     t = f_nz(c.write_low_ticks);
            PH_W_HOLD:    t = f_nz(c.write_slot_ticks);
            PH_W_REC:     t = f_nz(c.write_recover_ticks);
            PH_R_LOW:     t = f_nz(c.read_low_ticks);
            PH_R_SAMPLE:  t = TICK_W'(1);
            PH_R_WAIT:    t = f_nz(c.read_slot_ticks);
            default:      t = '0;
        endcase
        return t;
    endfunction

endpackage

/* rtl/owrm_cfg_regs.sv */
// Slot duration registers of the one-wire register master.
// Depends on owrm_pkg for register indexes, reset values and the t_owrm_cfg type.
module owrm_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [owrm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [owrm_pkg::TICK_W-1:0]     i_cfg_data,
    output owrm_pkg::t_owrm_cfg             o_cfg
);
    import owrm_pkg::*;

    t_owrm_cfg r_cfg;

    // Load reset values, then take writes by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks     <= RST_RESET_LOW;
            r_cfg.presence_wait_ticks <= RST_PRES_WAIT;
            r_cfg.reset_recover_ticks <= RST_RESET_RECOV;
            r_cfg.write_low_ticks     <= RST_WRITE_LOW;
            r_cfg.write_slot_ticks    <= RST_WRITE_SLOT;
            r_cfg.write_recover_ticks <= RST_WRITE_RECOV;
            r_cfg.read_low_ticks      <= RST_READ_LOW;
            r_cfg.read_slot_ticks     <= RST_READ_SLOT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESET_LOW:   r_cfg.reset_low_ticks     <= i_cfg_data;
                CFG_PRES_WAIT:   r_cfg.presence_wait_ticks <= i_cfg_data;
                CFG_RESET_RECOV: r_cfg.reset_recover_ticks <= i_cfg_data;
                CFG_WRITE_LOW:   r_cfg.write_low_ticks     <= i_cfg_data;
                CFG_WRITE_SLOT:  r_cfg.write_slot_ticks    <= i_cfg_data;
                CFG_WRITE_RECOV: r_cfg.write_recover_ticks <= i_cfg_data;
                CFG_READ_LOW:    r_cfg.read_low_ticks      <= i_cfg_data;
                CFG_READ_SLOT:   r_cfg.read_slot_ticks     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/owrm_step.sv */
// Next-state and result logic for one request of the one-wire register master.
// Depends on owrm_pkg for the state, request, result and configuration types.
module owrm_step (
    input  owrm_pkg::t_owrm_state  i_state,
    input  owrm_pkg::t_owrm_item   i_item,
    input  owrm_pkg::t_owrm_cfg    i_cfg,
    output owrm_pkg::t_owrm_state  o_state,
    output owrm_pkg::t_owrm_result o_result
);
    import owrm_pkg::*;

    t_owrm_state       n_st;
    t_owrm_state       w_drv;
    t_owrm_result      w_res;
    logic              w_start;
    logic [7:0]        w_sh;
    logic [2:0]        w_bc;
    logic [LEFT_W-1:0] w_bl;
    logic [LEFT_W-1:0] w_cnt;

    // Command start: only from idle
    assign w_start = ((i_item.func == FUNC_READ) || (i_item.func == FUNC_WRITE))
                     && (i_state.phase == PH_IDLE);

    // Saturate the read count
    assign w_cnt = (i_item.byte_count > 8'(MAX_READ_BYTES)) ? LEFT_W'(MAX_READ_BYTES)
                                                            : LEFT_W'(i_item.byte_count);

    // Advance the transaction by one request
    always_comb begin
        n_st  = i_state;
        w_res = '0;
        w_sh  = i_state.shift_byte;
        w_bc  = i_state.bit_counter;
        w_bl  = i_state.bytes_left;

        if (w_start) begin
            n_st.is_read     = (i_item.func == FUNC_READ);
            n_st.chosen_line = i_item.line_sel;
            n_st.saved_addr  = i_item.reg_addr;
            n_st.saved_data  = i_item.write_data;
            n_st.bytes_left  = (i_item.func == FUNC_READ) ? w_cnt : '0;
            n_st.bit_counter = '0;
            n_st.byte_stage  = '0;
            n_st.shift_byte  = '0;
            n_st.phase       = PH_RST_LOW;
            n_st.slot_timer  = f_slot_ticks(PH_RST_LOW, i_cfg);
        end else if ((i_item.func == FUNC_TICK) && (i_state.phase != PH_IDLE)) begin
            // Shift in a read bit and report a finished byte
            if (i_state.phase == PH_R_SAMPLE) begin
                w_sh = {i_item.line_sample, i_state.shift_byte[7:1]};
                w_bc = i_state.bit_counter + 3'd1;
                if (w_bc == '0) begin
                    w_res.byte_valid = 1'b1;
                    w_res.read_data  = w_sh;
                    w_res.byte_last  = (i_state.bytes_left == LEFT_W'(1));
                    if (i_state.bytes_left != '0) begin
                        w_bl = i_state.bytes_left - LEFT_W'(1);
                    end
                end
            end
            n_st.shift_byte  = w_sh;
            n_st.bit_counter = w_bc;
            n_st.bytes_left  = w_bl;

            // Presence sample on the last wait tick
            if ((i_state.phase == PH_PRES_WAIT) && (i_state.slot_timer <= TICK_W'(1))) begin
                w_res.presence_valid = 1'b1;
                w_res.present        = ~i_item.line_sample;
            end

            if (i_state.slot_timer > TICK_W'(1)) begin
                n_st.slot_timer = i_state.slot_timer - TICK_W'(1);
            end else begin
                case (i_state.phase)
                    PH_RST_LOW:   n_st.phase = PH_PRES_WAIT;
                    PH_PRES_WAIT: n_st.phase = PH_RECOVER;
                    PH_RECOVER: begin
                        n_st.shift_byte  = SKIP_ROM_CMD;
                        n_st.byte_stage  = '0;
                        n_st.bit_counter = '0;
                        n_st.phase       = PH_W_LOW;
                    end
                    PH_W_LOW:     n_st.phase = PH_W_HOLD;
                    PH_W_HOLD:    n_st.phase = PH_W_REC;
                    PH_W_REC: begin
                        n_st.shift_byte  = {1'b0, w_sh[7:1]};
                        n_st.bit_counter = w_bc + 3'd1;
                        if (n_st.bit_counter != '0) begin
                            n_st.phase = PH_W_LOW;
                        end else if (i_state.byte_stage == 2'd0) begin
                            // Address byte follows skip-ROM
                            n_st.byte_stage = 2'd1;
                            n_st.shift_byte = i_state.saved_addr
                                              | (i_state.is_read ? READ_FLAG : 8'h00);
                            n_st.phase      = PH_W_LOW;
                        end else if ((i_state.byte_stage == 2'd1) && i_state.is_read) begin
                            if (w_bl != '0) begin
                                n_st.shift_byte = '0;
                                n_st.phase      = PH_R_LOW;
                            end else begin
                                n_st.phase = PH_IDLE;
                            end
                        end else if (i_state.byte_stage == 2'd1) begin
                            n_st.byte_stage = 2'd2;
                            n_st.shift_byte = i_state.saved_data;
                            n_st.phase      = PH_W_LOW;
                        end else begin
                            n_st.phase = PH_IDLE;
                        end
                    end
                    PH_R_LOW:     n_st.phase = PH_R_SAMPLE;
                    PH_R_SAMPLE:  n_st.phase = PH_R_WAIT;
                    PH_R_WAIT: begin
                        if ((w_bc != '0) || (w_bl != '0)) begin
                            n_st.phase = PH_R_LOW;
                        end else begin
                            n_st.phase = PH_IDLE;
                        end
                    end
                    default:      n_st.phase = PH_IDLE;
                endcase
                n_st.slot_timer = f_slot_ticks(n_st.phase, i_cfg);
            end
        end

        // Line drive during this request
        w_drv = w_start ? n_st : i_state;
        case (w_drv.phase)
            PH_RST_LOW, PH_W_LOW, PH_R_LOW: begin
                w_res.drive_enable = 1'b1;
                w_res.drive_level  = 1'b0;
            end
            PH_W_HOLD: begin
                w_res.drive_enable = 1'b1;
                w_res.drive_level  = w_drv.shift_byte[0];
            end
            PH_W_REC: begin
                w_res.drive_enable = 1'b1;
                w_res.drive_level  = 1'b1;
            end
            default: begin
                w_res.drive_enable = 1'b0;
                w_res.drive_level  = 1'b0;
            end
        endcase
        w_res.active_line = w_drv.chosen_line;
        w_res.busy_res    = (w_drv.phase != PH_IDLE);
    end

    assign o_state  = n_st;
    assign o_result = w_res;

endmodule

/* rtl/one_wire_register_master.sv */
// One-wire register master: top level with state and result registers.
// Depends on owrm_pkg, owrm_cfg_regs and owrm_step.
// A request's result is registered and presented in the cycle after the request is accepted.
// One request per cycle while the output register is empty or being drained; the state register closes the loop.
// A result waiting in the output register does not block intake while it is taken.
// Reset (synchronous, active low): idle, counters cleared, slot registers at defaults.
module one_wire_register_master (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [owrm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [owrm_pkg::TICK_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_func,
    input  logic                           i_line_sel,
    input  logic [7:0]                     i_reg_addr,
    input  logic [7:0]                     i_byte_count,
    input  logic [7:0]                     i_write_data,
    input  logic                           i_line_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_drive_enable,
    output logic                           o_drive_level,
    output logic                           o_active_line,
    output logic                           o_busy_res,
    output logic                           o_presence_valid,
    output logic                           o_present,
    output logic                           o_byte_valid,
    output logic [7:0]                     o_read_data,
    output logic                           o_byte_last
);
    import owrm_pkg::*;

    t_owrm_cfg    w_cfg;
    t_owrm_item   w_item;
    t_owrm_state  r_state;
    t_owrm_state  n_state;
    t_owrm_result n_result;
    t_owrm_result r_result;
    logic         r_out_valid;
    logic         w_in_fire;

    owrm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Gather request fields
    assign w_item.func        = i_func;
    assign w_item.line_sel    = i_line_sel;
    assign w_item.reg_addr    = i_reg_addr;
    assign w_item.byte_count  = i_byte_count;
    assign w_item.write_data  = i_write_data;
    assign w_item.line_sample = i_line_sample;

    owrm_step u_step (
        .i_state  (r_state),
        .i_item   (w_item),
        .i_cfg    (w_cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Accept when the output register is empty or being drained
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign w_in_fire  = i_in_valid & o_in_ready;

    // Advance transaction state per accepted request; all-zero state is idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_in_fire) begin
            r_state <= n_state;
        end
    end

    // Hold result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_drive_enable   = r_result.drive_enable;
    assign o_drive_level    = r_result.drive_level;
    assign o_active_line    = r_result.active_line;
    assign o_busy_res       = r_result.busy_res;
    assign o_presence_valid = r_result.presence_valid;
    assign o_present        = r_result.present;
    assign o_byte_valid     = r_result.byte_valid;
    assign o_read_data      = r_result.read_data;
    assign o_byte_last      = r_result.byte_last;

endmodule
